// File: rtl/lpp_pkg.sv
// Package with the shared types and constants of the lossless pixel predictor.
package lpp_pkg;

  localparam int PIX_W    = 8;
  localparam int VAL_W    = 9;
  localparam int ROW_W    = 16;
  localparam int LWIDTH_W = 13;
  localparam int MODE_W   = 3;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [MODE_W-1:0] MODE_NONE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LEFT    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TOP     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AVERAGE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PAETH   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MED     = 3'd5;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [1:0] REG_DIRECTION    = 2'd0;
  localparam logic [1:0] REG_PRED_MODE    = 2'd1;
  localparam logic [1:0] REG_LINE_WIDTH   = 2'd2;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd3;

  localparam logic [MODE_W-1:0]   RST_MODE   = MODE_LEFT;
  localparam logic [LWIDTH_W-1:0] RST_WIDTH  = 13'd512;
  localparam logic [ROW_W-1:0]    RST_HEIGHT = 16'd512;

  localparam logic [PIX_W-1:0] PIX_MID = 8'd128;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef struct packed {
    logic                direction;
    logic [MODE_W-1:0]   mode;
    logic [LWIDTH_W-1:0] line_width;
    logic [ROW_W-1:0]    frame_height;
  } lpp_cfg_t;

  // Position of an item inside the frame, fixed at the input transfer.
  typedef struct packed {
    logic first_col;
    logic first_row;
    logic row_end;
    logic frame_end;
  } lpp_pos_t;

endpackage

// File: rtl/lpp_cfg.sv
// Configuration register file behind the APB-style port.
module lpp_cfg
  import lpp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output lpp_cfg_t          cfg
);

  lpp_cfg_t   cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction    <= DIR_ENCODE;
      cfg_r.mode         <= RST_MODE;
      cfg_r.line_width   <= RST_WIDTH;
      cfg_r.frame_height <= RST_HEIGHT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DIRECTION:    cfg_r.direction    <= pwdata[0];
        REG_PRED_MODE:    cfg_r.mode         <= pwdata[MODE_W-1:0];
        REG_LINE_WIDTH:   cfg_r.line_width   <= pwdata[LWIDTH_W-1:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_DIRECTION:    prdata[0]            = cfg_r.direction;
      REG_PRED_MODE:    prdata[MODE_W-1:0]   = cfg_r.mode;
      REG_LINE_WIDTH:   prdata[LWIDTH_W-1:0] = cfg_r.line_width;
      REG_FRAME_HEIGHT: prdata[ROW_W-1:0]    = cfg_r.frame_height;
      default:          prdata               = '0;
    endcase
  end

endmodule

// File: rtl/lpp_line_mem.sv
// Line store holding the previous row: one write port, one registered read port.
module lpp_line_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read, so a stalled item keeps its top pixel.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/lpp_pred.sv
// Neighbor prediction and residual or reconstruction arithmetic.
module lpp_pred
  import lpp_pkg::*;
(
  input  lpp_cfg_t                  cfg,
  input  lpp_pos_t                  pos,
  input  logic signed [VAL_W-1:0]   sample,
  input  logic [PIX_W-1:0]          left,
  input  logic [PIX_W-1:0]          top,
  input  logic [PIX_W-1:0]          top_left,
  output logic [PIX_W-1:0]          pixel,
  output logic signed [VAL_W-1:0]   result
);

  logic [PIX_W-1:0]   pred;
  logic [PIX_W-1:0]   avg;
  logic [PIX_W-1:0]   paeth;
  logic [PIX_W-1:0]   med;
  logic [PIX_W-1:0]   lo;
  logic [PIX_W-1:0]   hi;
  logic signed [10:0] pa;
  logic signed [10:0] pb;
  logic signed [10:0] pc;
  logic signed [10:0] d_a;
  logic signed [10:0] d_b;
  logic signed [10:0] d_c;
  logic signed [10:0] l_s;
  logic signed [10:0] t_s;
  logic signed [10:0] tl_s;
  logic signed [10:0] med_grad;
  logic signed [9:0]  recon;

  assign l_s  = signed'({3'b000, left});
  assign t_s  = signed'({3'b000, top});
  assign tl_s = signed'({3'b000, top_left});

  // Paeth distances of p = left + top - top_left to each neighbor.
  always_comb begin
    d_a = t_s - tl_s;
    d_b = l_s - tl_s;
    d_c = l_s + t_s - (tl_s <<< 1);
    pa  = (d_a < 0) ? -d_a : d_a;
    pb  = (d_b < 0) ? -d_b : d_b;
    pc  = (d_c < 0) ? -d_c : d_c;
    if ((pa <= pb) && (pa <= pc)) begin
      paeth = left;
    end else if (pb <= pc) begin
      paeth = top;
    end else begin
      paeth = top_left;
    end
  end

  always_comb begin
    avg      = PIX_W'(({1'b0, left} + {1'b0, top}) >> 1);
    lo       = (left < top) ? left : top;
    hi       = (left > top) ? left : top;
    med_grad = l_s + t_s - tl_s;
    if (top_left >= hi) begin
      med = lo;
    end else if (top_left <= lo) begin
      med = hi;
    end else begin
      // Strictly between lo and hi, so the gradient stays in 0..255.
      med = med_grad[PIX_W-1:0];
    end
  end

  always_comb begin
    if (pos.first_col && pos.first_row) begin
      pred = PIX_MID;
    end else begin
      case (cfg.mode)
        MODE_NONE: pred = '0;
        MODE_TOP:  pred = pos.first_row ? PIX_MID : top;
        MODE_AVERAGE, MODE_PAETH, MODE_MED: begin
          if (pos.first_col) begin
            pred = top;
          end else if (pos.first_row) begin
            pred = left;
          end else if (cfg.mode == MODE_AVERAGE) begin
            pred = avg;
          end else if (cfg.mode == MODE_PAETH) begin
            pred = paeth;
          end else begin
            pred = med;
          end
        end
        default:   pred = pos.first_col ? PIX_MID : left;
      endcase
    end
  end

  always_comb begin
    recon = 10'(sample) + signed'({2'b00, pred});
    if (cfg.direction == DIR_ENCODE) begin
      pixel  = sample[VAL_W-1] ? '0 : sample[PIX_W-1:0];
      result = signed'({1'b0, pixel}) - signed'({1'b0, pred});
    end else begin
      if (recon < 0) begin
        pixel = '0;
      end else if (recon > 10'sd255) begin
        pixel = PIX_MAX;
      end else begin
        pixel = recon[PIX_W-1:0];
      end
      result = signed'({1'b0, pixel});
    end
  end

endmodule

// File: rtl/lossless_pixel_predictor_codec.sv
// Top level of the lossless pixel predictor: counters, pipeline and output register.
//
// The codec takes one sample per clock in raster order while in_stall is low, and returns
// one value per sample, the residual in encode mode and the clamped pixel in decode mode,
// with row and frame end marks. The line store read is issued at the input transfer, the
// stage behind it forms the prediction and loads the output register, and the result is
// taken from that register. While the output is not stalled the sustained rate is one item per
// cycle, set by the single read and single write port of the line store; when a row is one
// pixel wide the pixel being written is forwarded to the next read. Input stall rises only
// while the output register holds a result that is not taken and another item waits behind
// it. The line store is not cleared after reset; no clearing pass runs, and the block is
// ready as soon as reset is released.
module lossless_pixel_predictor_codec
  import lpp_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [VAL_W-1:0]  in_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  out_value,
  output logic                     out_row_end,
  output logic                     out_frame_end,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > LWIDTH_W) ? CW + 1 : LWIDTH_W;

  lpp_cfg_t cfg;

  logic                    in_accept;
  logic                    s1_adv;
  logic [EW-1:0]           width_eff;
  logic [ROW_W-1:0]        height_eff;
  logic                    last_col;
  logic                    last_row;

  logic [CW-1:0]           col_r;
  logic [CW-1:0]           col_nxt;
  logic [ROW_W-1:0]        row_r;
  logic [ROW_W-1:0]        row_nxt;

  logic                    s1_valid_r;
  logic signed [VAL_W-1:0] s1_sample_r;
  lpp_pos_t                s1_pos_r;
  lpp_pos_t                pos_nxt;
  logic [CW-1:0]           s1_slot_r;
  logic                    s1_fwd_r;

  logic [PIX_W-1:0]        left_r;
  logic [PIX_W-1:0]        top_left_r;
  logic [PIX_W-1:0]        mem_rd;
  logic [PIX_W-1:0]        top;
  logic [PIX_W-1:0]        pixel;
  logic signed [VAL_W-1:0] result;

  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic                    out_row_end_r;
  logic                    out_frame_end_r;

  assign pready        = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

  assign s1_adv    = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall  = s1_valid_r & ~s1_adv;
  assign in_accept = in_valid & ~in_stall;

  lpp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Zero width or height counts as one; width saturates at the line store depth.
  always_comb begin
    if (cfg.line_width == '0) begin
      width_eff = EW'(1);
    end else if (EW'(cfg.line_width) > EW'(MAX_WIDTH)) begin
      width_eff = EW'(MAX_WIDTH);
    end else begin
      width_eff = EW'(cfg.line_width);
    end
    height_eff = (cfg.frame_height == '0) ? ROW_W'(1) : cfg.frame_height;
    last_col   = (EW'(col_r) + EW'(1)) >= width_eff;
    last_row   = ({1'b0, row_r} + 17'd1) >= {1'b0, height_eff};
    col_nxt    = last_col ? '0 : col_r + CW'(1);
    row_nxt    = last_col ? (last_row ? '0 : row_r + ROW_W'(1)) : row_r;
    pos_nxt.first_col = (col_r == '0);
    pos_nxt.first_row = (row_r == '0);
    pos_nxt.row_end   = last_col;
    pos_nxt.frame_end = last_col & last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // The read for the new item and the write of the leaving item can hit the same entry.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample_r <= in_sample;
      s1_pos_r    <= pos_nxt;
      s1_slot_r   <= col_r;
      s1_fwd_r    <= s1_adv & (s1_slot_r == col_r);
    end
  end

  lpp_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (PIX_W)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_slot_r),
    .wr_data (pixel),
    .rd_en   (in_accept),
    .rd_addr (col_r),
    .rd_data (mem_rd)
  );

  assign top = s1_fwd_r ? left_r : mem_rd;

  lpp_pred u_pred (
    .cfg      (cfg),
    .pos      (s1_pos_r),
    .sample   (s1_sample_r),
    .left     (left_r),
    .top      (top),
    .top_left (top_left_r),
    .pixel    (pixel),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      top_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        left_r      <= pixel;
        top_left_r  <= top;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_value_r     <= result;
      out_row_end_r   <= s1_pos_r.row_end;
      out_frame_end_r <= s1_pos_r.frame_end;
    end
  end

endmodule

// File: rtl/lpp_checker.sv
// Port checker for the lossless pixel predictor and its bind to the top level.
module lpp_checker
  import lpp_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [VAL_W-1:0] out_value,
  input logic                    out_row_end,
  input logic                    out_frame_end
);

  // The last pixel of a frame is always the last pixel of a row.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_frame_end || out_row_end))
    else $error("frame end without row end");

  // The input side only backs up behind a result that is held by the output stall.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output register can move");

  // A result that is not taken stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result does not change.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_value) && $stable(out_row_end)
                                  && $stable(out_frame_end)))
    else $error("stalled result changed");

endmodule

bind lossless_pixel_predictor_codec lpp_checker u_lpp_checker (.*);
